@@ hdl/wpf_pkg.sv @@
// wpf_pkg: shared types and constants of the wildcard path rule filter.
// No dependencies; used by the interfaces and all modules.
package wpf_pkg;

    localparam int MAX_RULES          = 3;
    localparam int RULE_COUNT_DEF     = 3;
    localparam int PATTERN_BYTES_DEF  = 16;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 64;
    localparam int RULE_W             = 2;

    // pattern characters
    localparam logic [7:0] CHAR_ANY = 8'h3F;   // '?'
    localparam logic [7:0] CHAR_RUN = 8'h2A;   // '*'
    localparam logic [7:0] CHAR_END = 8'h00;   // ends a pattern

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RULE0_LO      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INCLUDE_MASK  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_RULES_IN_USE  = 3'd7;

    // deciding_rule code when nothing matched
    localparam logic [RULE_W-1:0] NO_RULE = 2'd3;

    typedef struct packed {
        logic              include_res;
        logic [RULE_W-1:0] deciding_rule;
    } result_t;

    // signals handed from one position cell to the next
    typedef struct packed {
        logic in_pat;     // this and all earlier positions lie inside the pattern
        logic clo;        // closure over '*' of the held positions
        logic adv;        // position reached by consuming the current byte
        logic post_clo;   // closure over '*' of the stepped positions
    } link_t;

endpackage

@@ hdl/wpf_if.sv @@
// wpf_if: valid/ready channel interfaces for path bytes and verdicts.
// Depends on wpf_pkg.
interface wpf_path_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       last;

    modport source (output valid, output path_byte, output last, input ready);
    modport sink   (input valid, input path_byte, input last, output ready);
endinterface

interface wpf_verdict_if;
    logic                      valid;
    logic                      ready;
    logic                      include_res;
    logic [wpf_pkg::RULE_W-1:0] deciding_rule;

    modport source (output valid, output include_res, output deciding_rule, input ready);
    modport sink   (input valid, input include_res, input deciding_rule, output ready);
endinterface

@@ hdl/wildcard_path_rule_filter.sv @@
// wildcard_path_rule_filter: top level; configuration registers, one
// position-cell chain per rule, verdict priority and output queue.
// Depends on wpf_pkg, wpf_if and wpf_rule.
//
// Usage
//   path_in carries one path byte per item with a last flag; verdict_out
//   carries one verdict per path (include_res, deciding_rule). Both are
//   valid/ready channels; an item moves on a clock edge with both high.
//   A zero byte is never matched: with last it ends the path (alone it
//   is the empty path), without last it is dropped with no effect.
//   Rule patterns, include mask and rule count are written on the plain
//   cfg_* port, one register per cycle, between paths.
// Timing
//   One byte per cycle, back to back, while path_in.ready is high.
//   Every pattern position is a cell, so the item rate is set by the
//   combinational ripple of '*' closure along PATTERN_BYTES cells.
//   Each verdict is queued with its path's last byte, in path order.
//   A two-entry output queue lets path_in keep flowing while a verdict
//   waits; path_in.ready drops only when both entries are full.
// Reset
//   rst_n is asynchronous, active low: patterns and mask clear, no rules
//   enabled, every rule back at pattern position zero, queue empty.
module wildcard_path_rule_filter #(
    parameter int RULE_COUNT    = wpf_pkg::RULE_COUNT_DEF,
    parameter int PATTERN_BYTES = wpf_pkg::PATTERN_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    wpf_path_if.sink                        path_in,
    wpf_verdict_if.source                   verdict_out,
    input  logic                            cfg_we,
    input  logic [wpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    localparam int CHARS_W = 2 * wpf_pkg::CFG_DATA_W;

    // configuration registers
    logic [wpf_pkg::CFG_DATA_W-1:0] pat_lo_reg [RULE_COUNT];
    logic [wpf_pkg::CFG_DATA_W-1:0] pat_hi_reg [RULE_COUNT];
    logic [wpf_pkg::MAX_RULES-1:0]  include_mask_reg;
    logic [wpf_pkg::RULE_W-1:0]     rules_in_use_reg;

    logic                    in_acc;
    logic [RULE_COUNT-1:0]   match;
    wpf_pkg::result_t        verdict;

    // output queue
    wpf_pkg::result_t        q_reg [2];
    logic                    head_reg;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic                    push;
    logic                    pop;
    logic                    tail;

    assign in_acc = path_in.valid && path_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RULE_COUNT; r++)
            begin
                pat_lo_reg[r] <= '0;
                pat_hi_reg[r] <= '0;
            end
            include_mask_reg <= '0;
            rules_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int r = 0; r < RULE_COUNT; r++)
            begin
                if (cfg_index == wpf_pkg::CFG_INDEX_W'(wpf_pkg::REG_RULE0_LO + 2 * r))
                begin
                    pat_lo_reg[r] <= cfg_data;
                end
                if (cfg_index == wpf_pkg::CFG_INDEX_W'(wpf_pkg::REG_RULE0_LO + 2 * r + 1))
                begin
                    pat_hi_reg[r] <= cfg_data;
                end
            end
            if (cfg_index == wpf_pkg::REG_INCLUDE_MASK)
            begin
                include_mask_reg <= cfg_data[wpf_pkg::MAX_RULES-1:0];
            end
            if (cfg_index == wpf_pkg::REG_RULES_IN_USE)
            begin
                rules_in_use_reg <= cfg_data[wpf_pkg::RULE_W-1:0];
            end
        end
    end

    // one cell chain per rule
    for (genvar r = 0; r < RULE_COUNT; r++)
    begin : g_rule
        logic [CHARS_W-1:0] chars;

        assign chars = {pat_hi_reg[r], pat_lo_reg[r]};

        wpf_rule #(
            .PATTERN_BYTES (PATTERN_BYTES)
        ) u_rule (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_en   (in_acc),
            .path_last (path_in.last),
            .path_byte (path_in.path_byte),
            .pattern   (chars[PATTERN_BYTES*8-1:0]),
            .match     (match[r])
        );
    end

    // first enabled matching rule decides; rules past RULE_COUNT never exist
    always_comb
    begin
        verdict.include_res   = 1'b1;
        verdict.deciding_rule = wpf_pkg::NO_RULE;
        for (int r = RULE_COUNT - 1; r >= 0; r--)
        begin
            if (match[r] && (wpf_pkg::RULE_W'(r) < rules_in_use_reg))
            begin
                verdict.include_res   = include_mask_reg[r];
                verdict.deciding_rule = wpf_pkg::RULE_W'(r);
            end
        end
    end

    assign push = in_acc && path_in.last;
    assign pop  = verdict_out.valid && verdict_out.ready;
    assign tail = head_reg ^ count_reg[0];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail] <= verdict;
        end
    end

    assign path_in.ready             = (count_reg != 2'd2);
    assign verdict_out.valid         = (count_reg != 2'd0);
    assign verdict_out.include_res   = q_reg[head_reg].include_res;
    assign verdict_out.deciding_rule = q_reg[head_reg].deciding_rule;

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("verdict queue count out of range");

    // a finished path always leaves a verdict waiting
    a_verdict_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> verdict_out.valid)
        else $error("no verdict after last byte");

    // unmatched paths are included
    a_default_include: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_out.valid && (verdict_out.deciding_rule == wpf_pkg::NO_RULE)
        |-> verdict_out.include_res)
        else $error("unmatched path excluded");

    // deciding rule is a real rule
    a_rule_range: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_out.valid && (verdict_out.deciding_rule != wpf_pkg::NO_RULE)
        |-> (int'(verdict_out.deciding_rule) < RULE_COUNT))
        else $error("deciding rule out of range");
endmodule

@@ hdl/wpf_cell.sv @@
// wpf_cell: one pattern position of a rule; holds its live bit and
// passes advance and '*' closure to the next position. Depends on wpf_pkg.
module wpf_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  logic           path_last,
    input  logic [7:0]     path_byte,
    input  logic [7:0]     pat_char,
    input  wpf_pkg::link_t link_in,
    output wpf_pkg::link_t link_out,
    output logic           hit
);
    logic act_reg;
    logic act_next;
    logic in_pat_here;
    logic is_run;
    logic cur;
    logic nxt;
    logic stepped;
    logic post;
    logic byte_zero;

    assign byte_zero   = (path_byte == wpf_pkg::CHAR_END);
    assign in_pat_here = link_in.in_pat && (pat_char != wpf_pkg::CHAR_END);
    assign is_run      = (pat_char == wpf_pkg::CHAR_RUN);
    assign cur         = act_reg | link_in.clo;
    assign nxt         = (cur && in_pat_here && is_run) || link_in.adv;
    // a zero byte is never consumed
    assign stepped     = byte_zero ? act_reg : nxt;
    assign post        = stepped | link_in.post_clo;

    assign link_out.in_pat   = in_pat_here;
    assign link_out.clo      = cur && in_pat_here && is_run;
    assign link_out.adv      = cur && in_pat_here && !is_run &&
                               ((pat_char == wpf_pkg::CHAR_ANY) || (pat_char == path_byte));
    assign link_out.post_clo = post && in_pat_here && is_run;

    // this position is the pattern end
    assign hit = post && link_in.in_pat && (pat_char == wpf_pkg::CHAR_END);

    assign act_next = path_last ? FIRST : stepped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= FIRST;
        end
        else if (step_en)
        begin
            act_reg <= act_next;
        end
    end
endmodule

@@ hdl/wpf_rule.sv @@
// wpf_rule: chain of position cells for one rule plus the end position.
// Depends on wpf_pkg and wpf_cell.
module wpf_rule #(
    parameter int PATTERN_BYTES = wpf_pkg::PATTERN_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic                       path_last,
    input  logic [7:0]                 path_byte,
    input  logic [PATTERN_BYTES*8-1:0] pattern,
    output logic                       match
);
    wpf_pkg::link_t             links [PATTERN_BYTES+1];
    logic [PATTERN_BYTES-1:0]   hits;
    logic                       end_act_reg;
    logic                       end_stepped;
    logic                       end_post;
    logic                       end_hit;

    assign links[0] = '{in_pat: 1'b1, clo: 1'b0, adv: 1'b0, post_clo: 1'b0};

    for (genvar p = 0; p < PATTERN_BYTES; p++)
    begin : g_cell
        wpf_cell #(
            .FIRST (p == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_en   (step_en),
            .path_last (path_last),
            .path_byte (path_byte),
            .pat_char  (pattern[p*8 +: 8]),
            .link_in   (links[p]),
            .link_out  (links[p+1]),
            .hit       (hits[p])
        );
    end

    // position after a full-length pattern
    assign end_stepped = (path_byte == wpf_pkg::CHAR_END) ? end_act_reg
                                                          : links[PATTERN_BYTES].adv;
    assign end_post    = end_stepped | links[PATTERN_BYTES].post_clo;
    assign end_hit     = end_post && links[PATTERN_BYTES].in_pat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_act_reg <= 1'b0;
        end
        else if (step_en)
        begin
            end_act_reg <= path_last ? 1'b0 : end_stepped;
        end
    end

    assign match = (|hits) | end_hit;
endmodule
